// ===== design/wave_stencil_update_macros.svh =====
// assertion macros for the wave stencil update block
// expects clk and arst_n in the scope of each use
`ifndef WAVE_STENCIL_UPDATE_MACROS_SVH
`define WAVE_STENCIL_UPDATE_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every clock edge outside reset
`define WSU_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("wave_stencil_update: assertion failed");

// expression must never be true outside reset
`define WSU_NEVER(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
	else $error("wave_stencil_update: forbidden condition seen");

`else

`define WSU_ASSERT(lbl, prop)
`define WSU_NEVER(lbl, expr)

`endif

`endif

// ===== design/wsu_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants of the wave stencil update block
// no dependencies
package wsu_pkg;

	localparam int SAMPLE_WIDTH = 16;
	localparam int COEF_W       = 16;
	localparam int CFG_IDX_W    = 1;
	localparam int CFG_DATA_W   = 16;

	// laplacian of four neighbors minus four times the center
	localparam int LAP_W  = SAMPLE_WIDTH + 3;
	// unsigned coefficient (sign bit added) times laplacian
	localparam int PROD_W = LAP_W + COEF_W + 1;
	// 2*cur - prev
	localparam int BASE_W = SAMPLE_WIDTH + 2;
	// product after the q0.16 scaling
	localparam int RND_W  = PROD_W - COEF_W;
	localparam int V_W    = RND_W + 1;

	localparam int FRAC_SHIFT  = 16;
	localparam int START_SHIFT = 17;

	localparam logic [PROD_W-1:0] HALF_STD   = PROD_W'(1) << (FRAC_SHIFT - 1);
	localparam logic [PROD_W-1:0] HALF_START = PROD_W'(1) << (START_SHIFT - 1);

	localparam logic signed [V_W-1:0] SAT_MAX =
		{{(V_W - SAMPLE_WIDTH + 1){1'b0}}, {(SAMPLE_WIDTH - 1){1'b1}}};
	localparam logic signed [V_W-1:0] SAT_MIN =
		{{(V_W - SAMPLE_WIDTH + 1){1'b1}}, {(SAMPLE_WIDTH - 1){1'b0}}};

	localparam logic [COEF_W-1:0] R2_RESET = 16'd16384;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_R2_COEF    = 1'b0,
		REG_START_MODE = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		PH_EMPTY      = 2'd0,
		PH_HELD_FIRST = 2'd1,
		PH_HELD_INNER = 2'd2
	} phase_t;

	typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

	typedef struct packed {
		logic signed [LAP_W-1:0] lap;
		sample_t                 center;
		sample_t                 prev;
		logic                    has_held;
		logic                    held_zero;
		logic                    last;
	} s1_t;

	typedef struct packed {
		logic signed [PROD_W-1:0] prod;
		logic signed [BASE_W-1:0] base;
		logic                     start;
		logic                     has_held;
		logic                     held_zero;
		logic                     last;
	} s2_t;

	typedef struct packed {
		sample_t next_value;
		logic    saturated;
		logic    row_end;
	} word_t;

	typedef struct packed {
		word_t held;
		logic  has_held;
		logic  last;
	} item_t;

	typedef struct packed {
		logic pend;
		logic load_ok;
	} obuf_stat_t;

	localparam word_t ROW_END_WORD = '{next_value: '0, saturated: 1'b0, row_end: 1'b1};

endpackage

// ===== design/wsu_in_if.sv =====
`timescale 1ns / 1ps
// input channel: one grid column slice per word
// depends on wsu_pkg
interface wsu_in_if;
	logic              valid;
	logic              ready;
	wsu_pkg::sample_t  up_value;
	wsu_pkg::sample_t  center_value;
	wsu_pkg::sample_t  down_value;
	wsu_pkg::sample_t  prev_value;
	logic              edge_row;
	logic              last_col;

	modport source (output valid, up_value, center_value, down_value, prev_value,
		edge_row, last_col, input ready);
	modport sink (input valid, up_value, center_value, down_value, prev_value,
		edge_row, last_col, output ready);
endinterface

// ===== design/wsu_out_if.sv =====
`timescale 1ns / 1ps
// output channel: one updated grid point per word
// depends on wsu_pkg
interface wsu_out_if;
	logic              valid;
	logic              ready;
	wsu_pkg::sample_t  next_value;
	logic              saturated;
	logic              row_end;

	modport source (output valid, next_value, saturated, row_end, input ready);
	modport sink (input valid, next_value, saturated, row_end, output ready);
endinterface

// ===== design/wsu_window.sv =====
`timescale 1ns / 1ps
// two-column window, column phase and laplacian; feeds the first stage register
// depends on wsu_pkg, wsu_in_if
module wsu_window (
	input  logic          clk,
	input  logic          arst_n,
	wsu_in_if.sink        samples,
	input  logic          s1_ready,
	output logic          valid_s1,
	output wsu_pkg::s1_t  stage_s1
);

	wsu_pkg::phase_t  phase_q, phase_d;
	wsu_pkg::sample_t left2_center_q, left_center_q, left_up_q, left_down_q, left_prev_q;
	logic             held_edge_q;
	logic             accept;
	logic             has_held, held_zero;
	logic signed [wsu_pkg::LAP_W-1:0] lap;

	assign samples.ready = !valid_s1 || s1_ready;
	assign accept = samples.valid && samples.ready;

	// held column uses the incoming center as its right neighbor
	assign lap = wsu_pkg::LAP_W'(left_up_q) + wsu_pkg::LAP_W'(left_down_q)
		+ wsu_pkg::LAP_W'(left2_center_q) + wsu_pkg::LAP_W'(samples.center_value)
		- (wsu_pkg::LAP_W'(left_center_q) <<< 2);

	always_comb begin
		has_held  = 1'b1;
		held_zero = held_edge_q;
		phase_d   = wsu_pkg::PH_HELD_INNER;
		unique case (phase_q)
			wsu_pkg::PH_EMPTY: begin
				has_held = 1'b0;
				phase_d  = wsu_pkg::PH_HELD_FIRST;
			end
			wsu_pkg::PH_HELD_FIRST: begin
				held_zero = 1'b1;
			end
			wsu_pkg::PH_HELD_INNER: begin
				held_zero = held_edge_q;
			end
			default: begin
				held_zero = held_edge_q;
			end
		endcase
		if (samples.last_col) begin
			phase_d = wsu_pkg::PH_EMPTY;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= wsu_pkg::PH_EMPTY;
			left2_center_q <= '0;
			left_center_q  <= '0;
			left_up_q      <= '0;
			left_down_q    <= '0;
			left_prev_q    <= '0;
			held_edge_q    <= 1'b0;
		end else if (accept) begin
			phase_q        <= phase_d;
			left2_center_q <= left_center_q;
			left_center_q  <= samples.center_value;
			left_up_q      <= samples.up_value;
			left_down_q    <= samples.down_value;
			left_prev_q    <= samples.prev_value;
			held_edge_q    <= samples.edge_row;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (samples.ready) begin
			valid_s1 <= samples.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			stage_s1.lap       <= lap;
			stage_s1.center    <= left_center_q;
			stage_s1.prev      <= left_prev_q;
			stage_s1.has_held  <= has_held;
			stage_s1.held_zero <= held_zero;
			stage_s1.last      <= samples.last_col;
		end
	end

endmodule

// ===== design/wsu_calc.sv =====
`timescale 1ns / 1ps
// coefficient multiply stage, then rounding, update sum and saturation
// depends on wsu_pkg
module wsu_calc (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [wsu_pkg::COEF_W-1:0]   r2_coef,
	input  logic                         start_mode,
	input  logic                         valid_s1,
	input  wsu_pkg::s1_t                 stage_s1,
	output logic                         s1_ready,
	input  logic                         load_ok,
	output logic                         item_valid,
	output wsu_pkg::item_t               item
);

	logic                                valid_s2;
	wsu_pkg::s2_t                        stage_s2;
	logic signed [wsu_pkg::COEF_W:0]     coef;
	logic signed [wsu_pkg::PROD_W-1:0]   prod;
	logic signed [wsu_pkg::BASE_W-1:0]   base;
	logic signed [wsu_pkg::PROD_W-1:0]   rsum, rshift;
	logic signed [wsu_pkg::RND_W-1:0]    rnd;
	logic signed [wsu_pkg::V_W-1:0]      sum;
	wsu_pkg::word_t                      word;

	assign s1_ready = !valid_s2 || load_ok;
	assign coef = {1'b0, r2_coef};
	assign prod = wsu_pkg::PROD_W'(coef) * wsu_pkg::PROD_W'(stage_s1.lap);

	always_comb begin
		if (start_mode) begin
			base = wsu_pkg::BASE_W'(stage_s1.center);
		end else begin
			base = (wsu_pkg::BASE_W'(stage_s1.center) <<< 1) - wsu_pkg::BASE_W'(stage_s1.prev);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s1_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_ready && valid_s1) begin
			stage_s2.prod      <= prod;
			stage_s2.base      <= base;
			stage_s2.start     <= start_mode;
			stage_s2.has_held  <= stage_s1.has_held;
			stage_s2.held_zero <= stage_s1.held_zero;
			stage_s2.last      <= stage_s1.last;
		end
	end

	// round to nearest, ties up: add half then arithmetic shift
	always_comb begin
		if (stage_s2.start) begin
			rsum   = stage_s2.prod + $signed(wsu_pkg::HALF_START);
			rshift = rsum >>> wsu_pkg::START_SHIFT;
			rnd    = rshift[wsu_pkg::RND_W-1:0];
			sum    = wsu_pkg::V_W'(stage_s2.base) - wsu_pkg::V_W'(rnd);
		end else begin
			rsum   = stage_s2.prod + $signed(wsu_pkg::HALF_STD);
			rshift = rsum >>> wsu_pkg::FRAC_SHIFT;
			rnd    = rshift[wsu_pkg::RND_W-1:0];
			sum    = wsu_pkg::V_W'(stage_s2.base) + wsu_pkg::V_W'(rnd);
		end
		word.row_end = 1'b0;
		if (stage_s2.held_zero) begin
			word.next_value = '0;
			word.saturated  = 1'b0;
		end else if (sum > wsu_pkg::SAT_MAX) begin
			word.next_value = wsu_pkg::SAT_MAX[wsu_pkg::SAMPLE_WIDTH-1:0];
			word.saturated  = 1'b1;
		end else if (sum < wsu_pkg::SAT_MIN) begin
			word.next_value = wsu_pkg::SAT_MIN[wsu_pkg::SAMPLE_WIDTH-1:0];
			word.saturated  = 1'b1;
		end else begin
			word.next_value = sum[wsu_pkg::SAMPLE_WIDTH-1:0];
			word.saturated  = 1'b0;
		end
	end

	assign item_valid    = valid_s2;
	assign item.held     = word;
	assign item.has_held = stage_s2.has_held;
	assign item.last     = stage_s2.last;

endmodule

// ===== design/wsu_obuf.sv =====
`timescale 1ns / 1ps
// output word register with a pending row-end word for the last column
// depends on wsu_pkg, wsu_out_if
module wsu_obuf (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	input  wsu_pkg::item_t       item,
	output wsu_pkg::obuf_stat_t  stat,
	wsu_out_if.source            results
);

	wsu_pkg::word_t out_q;
	logic           out_valid_q;
	logic           pend_q;
	logic           load_ok;
	logic           load;

	assign load_ok = (!out_valid_q || results.ready) && !pend_q;
	assign load    = item_valid && load_ok;

	assign stat.pend    = pend_q;
	assign stat.load_ok = load_ok;

	assign results.valid      = out_valid_q;
	assign results.next_value = out_q.next_value;
	assign results.saturated  = out_q.saturated;
	assign results.row_end    = out_q.row_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pend_q      <= 1'b0;
		end else if (load) begin
			out_valid_q <= item.has_held || item.last;
			pend_q      <= item.has_held && item.last;
		end else if (load_ok) begin
			out_valid_q <= 1'b0;
		end else if (results.ready && pend_q) begin
			pend_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= item.has_held ? item.held : wsu_pkg::ROW_END_WORD;
		end else if (results.ready && pend_q) begin
			out_q <= wsu_pkg::ROW_END_WORD;
		end
	end

endmodule

// ===== design/wave_stencil_update.sv =====
`timescale 1ns / 1ps
// wave stencil update: one time step of the 2-d wave equation, streamed
// usage:
//  - samples carries one column slice per word (up, center, down, previous
//    field, edge_row, last_col); results carries one updated point per word
//  - each column's result leaves with the next column's word, since its right
//    neighbor is needed; the last column of a row of two or more columns yields
//    two words, the held column's result and then a zero word with row_end set;
//    a one-column row yields only the row-end word
//  - a result passes through stage s1, stage s2 and then the output register
//  - one word per cycle while results.ready is high; while a row-end word is
//    pending behind a held result, the output register takes no new item
//  - the rate is set by the output register, which shows one word per cycle
//  - a stalled receiver holds the output word; stage s1 and s2 keep filling
//    until they back up, then samples.ready drops
//  - reset clears the window, the column phase and all valid flags, and
//    loads r2_coef = 0.25, start_mode = 0
//  - config writes (cfg_wr_en, cfg_index, cfg_data) belong to idle periods
`include "wave_stencil_update_macros.svh"
module wave_stencil_update (
	input  logic                             clk,
	input  logic                             arst_n,
	wsu_in_if.sink                           samples,
	wsu_out_if.source                        results,
	input  logic                             cfg_wr_en,
	input  logic [wsu_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [wsu_pkg::CFG_DATA_W-1:0]   cfg_data
);

	// configuration registers
	logic [wsu_pkg::COEF_W-1:0] r2_coef_q;
	logic                       start_mode_q;

	// pipeline links
	logic                 valid_s1;
	wsu_pkg::s1_t         stage_s1;
	logic                 s1_ready;
	logic                 item_valid;
	wsu_pkg::item_t       item;
	wsu_pkg::obuf_stat_t  stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r2_coef_q    <= wsu_pkg::R2_RESET;
			start_mode_q <= 1'b0;
		end else if (cfg_wr_en) begin
			unique case (wsu_pkg::cfg_reg_t'(cfg_index))
				wsu_pkg::REG_R2_COEF: begin
					r2_coef_q <= cfg_data[wsu_pkg::COEF_W-1:0];
				end
				wsu_pkg::REG_START_MODE: begin
					start_mode_q <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	// window and laplacian, registered into stage s1
	wsu_window u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.samples  (samples),
		.s1_ready (s1_ready),
		.valid_s1 (valid_s1),
		.stage_s1 (stage_s1)
	);

	// coefficient product in stage s2, then rounding and saturation
	wsu_calc u_calc (
		.clk        (clk),
		.arst_n     (arst_n),
		.r2_coef    (r2_coef_q),
		.start_mode (start_mode_q),
		.valid_s1   (valid_s1),
		.stage_s1   (stage_s1),
		.s1_ready   (s1_ready),
		.load_ok    (stat.load_ok),
		.item_valid (item_valid),
		.item       (item)
	);

	// output word register and the row-end word behind it
	wsu_obuf u_obuf (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item       (item),
		.stat       (stat),
		.results    (results)
	);

	// a pending row-end word always sits behind a shown word
	`WSU_ASSERT(a_pend_behind_word, stat.pend |-> results.valid)
	// while the row-end word waits, the shown word is the held result
	`WSU_ASSERT(a_pend_held_first, stat.pend |-> !results.row_end)
	// row-end words are boundary zeros
	`WSU_NEVER(a_row_end_zero, results.valid && results.row_end && (results.saturated || results.next_value != '0))
	// once the row-end word is shown, the pending flag is gone
	`WSU_ASSERT(a_pend_clears, stat.pend && results.ready |=> !stat.pend)

endmodule

// ===== tb/wave_stencil_update_tb.sv =====
`timescale 1ns / 1ps
// self-checking bench for wave_stencil_update: streams grid rows, predicts each point
// depends on wsu_pkg, wsu_in_if, wsu_out_if and the wave_stencil_update block
module wave_stencil_update_tb;
	import wsu_pkg::*;

	// run limits
	localparam int CYCLE_LIMIT   = 500000;
	localparam int SETTLE_CYCLES = 8;
	localparam int LONG_HOLD     = 300;
	localparam int NUM_PHASES    = 10;
	localparam int PHASE_WORDS   = 100;

	// sample styles for stimulus
	localparam int STYLE_RANDOM  = 0;
	localparam int STYLE_SMOOTH  = 1;
	localparam int STYLE_EXTREME = 2;

	// predicts the stencil results and holds the words still to come
	class stencil_scoreboard;
		logic [COEF_W-1:0] r2;
		logic              start;
		sample_t           held_left;
		sample_t           held_mid;
		sample_t           held_up;
		sample_t           held_down;
		sample_t           held_prev;
		logic              held_edge;
		phase_t            phase;
		word_t             expected_q[$];
		int                err_count;
		int                n_results;

		function new();
			r2 = R2_RESET;
			start = 1'b0;
			held_left = '0;
			held_mid = '0;
			held_up = '0;
			held_down = '0;
			held_prev = '0;
			held_edge = 1'b0;
			phase = PH_EMPTY;
			err_count = 0;
			n_results = 0;
		endfunction

		function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_R2_COEF: r2 = data[COEF_W-1:0];
				REG_START_MODE: start = data[0];
				default: ;
			endcase
		endfunction

		// result of the held column once its right neighbor is known
		function word_t held_word(sample_t right);
			word_t  w;
			longint lap;
			longint prod;
			longint v;
			longint hi;
			longint lo;
			w = '0;
			if (held_edge || phase != PH_HELD_INNER)
				return w;
			hi = (longint'(1) <<< (SAMPLE_WIDTH - 1)) - 1;
			lo = -hi - 1;
			lap = longint'(held_up) + longint'(held_down) + longint'(held_left)
				+ longint'(right) - 4 * longint'(held_mid);
			prod = longint'(r2) * lap;
			// adding half then flooring rounds ties toward plus infinity
			if (start)
				v = longint'(held_mid) - ((prod + 65536) >>> START_SHIFT);
			else
				v = 2 * longint'(held_mid) - longint'(held_prev)
					+ ((prod + 32768) >>> FRAC_SHIFT);
			if (v > hi) begin
				v = hi;
				w.saturated = 1'b1;
			end else if (v < lo) begin
				v = lo;
				w.saturated = 1'b1;
			end
			w.next_value = sample_t'(v);
			return w;
		endfunction

		function void note_sample(sample_t up_v, sample_t mid_v, sample_t down_v,
			sample_t prev_v, logic row_is_edge, logic col_is_last);
			word_t w;
			if (phase != PH_EMPTY)
				expected_q.push_back(held_word(mid_v));
			held_left = held_mid;
			held_mid = mid_v;
			held_up = up_v;
			held_down = down_v;
			held_prev = prev_v;
			held_edge = row_is_edge;
			phase = (phase == PH_EMPTY) ? PH_HELD_FIRST : PH_HELD_INNER;
			if (col_is_last) begin
				w = '0;
				w.row_end = 1'b1;
				expected_q.push_back(w);
				phase = PH_EMPTY;
			end
		endfunction

		function void report(string msg);
			if (err_count < 50)
				$display("mismatch: %s", msg);
			err_count++;
		endfunction

		function void check_result(sample_t v, logic sat, logic re);
			word_t w;
			n_results++;
			if (expected_q.size() == 0) begin
				report($sformatf("result %0d arrived with nothing expected", n_results));
				return;
			end
			w = expected_q.pop_front();
			if (v !== w.next_value)
				report($sformatf("result %0d next_value got %0d want %0d",
					n_results, v, w.next_value));
			if (sat !== w.saturated)
				report($sformatf("result %0d saturated got %b want %b",
					n_results, sat, w.saturated));
			if (re !== w.row_end)
				report($sformatf("result %0d row_end got %b want %b",
					n_results, re, w.row_end));
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	wsu_in_if  samples_if();
	wsu_out_if results_if();

	stencil_scoreboard sb;

	// percent chance that either side starts an idle gap; zero gives back-to-back traffic
	int idle_pct;
	// asks the receiver for one long stall
	logic hold_req;
	int cycle_count = 0;

	wave_stencil_update dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.samples   (samples_if),
		.results   (results_if),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// 10 ns clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// hard stop in case the block hangs or loses words
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// gap length: mostly none, mostly short, a few long
	function automatic int pick_gap();
		if ($urandom_range(99) >= idle_pct)
			return 0;
		if ($urandom_range(9) < 8)
			return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	// smooth samples stay near a row base so most results do not clip
	function automatic sample_t pick_sample(int style, int base);
		int v;
		case (style)
			STYLE_SMOOTH: begin
				v = base + int'($urandom_range(600)) - 300;
				if (v > 32767)
					v = 32767;
				if (v < -32768)
					v = -32768;
				return sample_t'(v);
			end
			STYLE_EXTREME: begin
				case ($urandom_range(4))
					0: return sample_t'(32767);
					1: return sample_t'(-32768);
					2: return sample_t'(0);
					3: return sample_t'(-1);
					default: return sample_t'(1);
				endcase
			end
			default: return sample_t'($urandom);
		endcase
	endfunction

	// mostly medium rows, some one or two columns, a few long ones
	function automatic int pick_row_len();
		int r;
		r = $urandom_range(99);
		if (r < 8)
			return 1;
		if (r < 16)
			return 2;
		if (r < 90)
			return $urandom_range(12, 3);
		return $urandom_range(48, 13);
	endfunction

	// register write on the plain config port, only while the block is idle
	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		sb.write_reg(idx, data);
	endtask

	// offer one column word, wait for the handshake, then maybe idle
	task automatic send_word(sample_t up_v, sample_t mid_v, sample_t down_v,
		sample_t prev_v, logic row_is_edge, logic col_is_last);
		int gap;
		@(negedge clk);
		samples_if.valid = 1'b1;
		samples_if.up_value = up_v;
		samples_if.center_value = mid_v;
		samples_if.down_value = down_v;
		samples_if.prev_value = prev_v;
		samples_if.edge_row = row_is_edge;
		samples_if.last_col = col_is_last;
		do
			@(posedge clk);
		while (samples_if.ready !== 1'b1);
		sb.note_sample(up_v, mid_v, down_v, prev_v, row_is_edge, col_is_last);
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			samples_if.valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// one grid row; now and then the edge flag flips or the row ends early
	task automatic send_row(int ncols, int style);
		int   base;
		logic edge_all;
		logic edge_c;
		logic end_c;
		base = int'($urandom_range(40000)) - 20000;
		edge_all = ($urandom_range(99) < 15);
		for (int c = 0; c < ncols; c++) begin
			edge_c = edge_all;
			if ($urandom_range(99) < 5)
				edge_c = ~edge_c;
			end_c = (c == ncols - 1) || ($urandom_range(99) < 2);
			send_word(pick_sample(style, base), pick_sample(style, base),
				pick_sample(style, base), pick_sample(style, base), edge_c, end_c);
		end
	endtask

	// stop offering and wait until every predicted word has come out
	task automatic wait_for_results();
		@(negedge clk);
		samples_if.valid = 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// receiver: random stalls, plus one long stall on request
	initial begin : receiver
		int stall_left;
		logic hold_done;
		stall_left = 0;
		hold_done = 1'b0;
		results_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				results_if.ready = 1'b0;
				stall_left--;
			end else if (hold_req === 1'b1 && !hold_done) begin
				// long hold so the pipeline backs up into samples.ready
				hold_done = 1'b1;
				stall_left = LONG_HOLD - 1;
				results_if.ready = 1'b0;
			end else begin
				stall_left = pick_gap();
				results_if.ready = (stall_left == 0);
				if (stall_left > 0)
					stall_left--;
			end
		end
	end

	// every accepted result word goes to the checker
	always @(posedge clk) begin
		if (arst_n && results_if.valid === 1'b1 && results_if.ready === 1'b1)
			sb.check_result(results_if.next_value, results_if.saturated,
				results_if.row_end);
	end

	initial begin : stimulus
		int n;
		int phase_words;
		int style;
		logic [CFG_DATA_W-1:0] start_word;
		sb = new();
		idle_pct = 30;
		hold_req = 1'b0;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = REG_R2_COEF;
		cfg_data = '0;
		samples_if.valid = 1'b0;
		samples_if.up_value = '0;
		samples_if.center_value = '0;
		samples_if.down_value = '0;
		samples_if.prev_value = '0;
		samples_if.edge_row = 1'b0;
		samples_if.last_col = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset coefficients: one-column row, then a two-column row
		send_word(16'sd100, -16'sd200, 16'sd300, 16'sd7, 1'b0, 1'b1);
		send_word(16'sd1, 16'sd2, 16'sd3, 16'sd4, 1'b0, 1'b0);
		send_word(-16'sd5, 16'sd6, -16'sd7, 16'sd8, 1'b0, 1'b1);
		wait_for_results();

		// full coefficient: drive the sum past both rails
		write_reg(REG_R2_COEF, 16'hffff);
		send_word(16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0);
		send_word(16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768, 1'b0, 1'b0);
		send_word(-16'sd32768, 16'sd32767, -16'sd32768, -16'sd32768, 1'b0, 1'b0);
		send_word(16'sd0, 16'sd0, 16'sd0, 16'sd32767, 1'b0, 1'b0);
		send_word(16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b1);
		// boundary row gives zeros even with extreme samples
		send_word(16'sd32767, -16'sd32768, 16'sd32767, 16'sd32767, 1'b1, 1'b0);
		send_word(-16'sd32768, 16'sd32767, -16'sd32768, -16'sd32768, 1'b1, 1'b0);
		send_word(16'sd32767, -16'sd32768, 16'sd32767, 16'sd32767, 1'b1, 1'b1);
		wait_for_results();

		// first-step update, upper config bits set to show they are ignored
		write_reg(REG_START_MODE, 16'hffff);
		send_word(16'sd0, 16'sd32767, 16'sd0, 16'sd0, 1'b0, 1'b0);
		send_word(16'sd32767, -16'sd32768, 16'sd32767, 16'sd32767, 1'b0, 1'b0);
		send_word(-16'sd32768, 16'sd32767, -16'sd32768, -16'sd32768, 1'b0, 1'b0);
		send_word(16'sd0, -16'sd32768, 16'sd0, 16'sd0, 1'b0, 1'b1);
		wait_for_results();

		// half coefficient: laplacian of minus one and plus one hit rounding ties
		write_reg(REG_R2_COEF, 16'h8000);
		write_reg(REG_START_MODE, 16'hfffe);
		send_word(16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0);
		send_word(-16'sd1, 16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0);
		send_word(16'sd1, 16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0);
		send_word(16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b1);
		wait_for_results();

		// random rows under several settings; phases end at a row end
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			start_word = CFG_DATA_W'($urandom);
			case (ph)
				0: begin
					write_reg(REG_R2_COEF, 16'hffff);
					start_word[0] = 1'b0;
				end
				1: begin
					write_reg(REG_R2_COEF, 16'h0000);
					start_word[0] = 1'b1;
				end
				2: begin
					write_reg(REG_R2_COEF, 16'hffff);
					start_word[0] = 1'b1;
				end
				3: begin
					write_reg(REG_R2_COEF, R2_RESET);
					start_word[0] = 1'b0;
				end
				default: write_reg(REG_R2_COEF, CFG_DATA_W'($urandom));
			endcase
			write_reg(REG_START_MODE, start_word);
			// some phases run with no idling at all
			idle_pct = (ph % 4 == 1) ? 0 : 30;
			// long receiver stall while the sender keeps offering
			if (ph == 3)
				hold_req = 1'b1;
			phase_words = 0;
			while (phase_words < PHASE_WORDS) begin
				n = pick_row_len();
				style = $urandom_range(99);
				if (style < 55)
					style = STYLE_SMOOTH;
				else if (style < 80)
					style = STYLE_RANDOM;
				else
					style = STYLE_EXTREME;
				send_row(n, style);
				phase_words += n;
			end
			wait_for_results();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.err_count == 0 && sb.pending() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+design
design/wsu_pkg.sv
design/wsu_in_if.sv
design/wsu_out_if.sv
design/wsu_window.sv
design/wsu_calc.sv
design/wsu_obuf.sv
design/wave_stencil_update.sv
tb/wave_stencil_update_tb.sv
